// ===== rtl/trimmed_mean_battery_gauge_top_defines.svh =====
// Assertion helpers shared by the gauge modules.
`ifndef TRIMMED_MEAN_BATTERY_GAUGE_TOP_DEFINES_SVH
`define TRIMMED_MEAN_BATTERY_GAUGE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TMBG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TMBG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tmbg_pkg.sv =====
package tmbg_pkg;

    // Field widths
    localparam int ADC_W   = 12;
    localparam int MV_W    = 12;
    localparam int LEVEL_W = 7;
    localparam int SUM_W   = 18;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    // Scaling of a converter count to millivolts: count * 3300 / 4096
    localparam int MV_FULL_SCALE = 3300;
    localparam int SCALED_W      = ADC_W + MV_W;

    // Window: 2^LOG2_KEPT kept samples plus the dropped min and max
    localparam int LOG2_KEPT  = 3;
    localparam int WINDOW_LEN = (1 << LOG2_KEPT) + 2;
    localparam int COUNT_W    = $clog2(WINDOW_LEN);
    localparam logic [MV_W-1:0] MIN_INIT = '1;

    // Level mapping
    localparam int STEP_MV     = 35;
    localparam int LEVEL_FULL  = 100;
    localparam int LEVEL_STEP  = 10;
    localparam int STEPS_FULL  = LEVEL_FULL / LEVEL_STEP;

    // Reciprocal of STEP_MV: floor(d / STEP_MV) == (d * RECIP) >> RECIP_SHIFT
    // exactly for every 12-bit d, since the rounding error stays below STEP_MV.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(STEP_MV) - 64'd1) / 64'(STEP_MV));
    localparam int PROD_W = MV_W + RECIP_W;

    // Register reset values
    localparam logic [MV_W-1:0] EMPTY_MV_RESET = 12'd1700;
    localparam logic [MV_W-1:0] FULL_MV_RESET  = 12'd2050;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_MV = 8'd0,
        CFG_FULL_MV  = 8'd1
    } tmbg_cfg_idx_t;

    // Closed window totals handed to the level stage
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [MV_W-1:0]  max;
        logic [MV_W-1:0]  min;
    } tmbg_win_t;

endpackage

// ===== rtl/tmbg_window.sv =====
`include "trimmed_mean_battery_gauge_top_defines.svh"

module tmbg_window
    import tmbg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  logic [ADC_W-1:0] adc_sample,
    output logic             win_valid,
    input  logic             win_ready,
    output tmbg_win_t        win
);

    logic [SCALED_W-1:0] scaled;
    logic                accept;
    logic                last;
    logic                take_mv;

    logic                mv_valid_reg, mv_valid_next;
    logic [MV_W-1:0]     mv_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [MV_W-1:0]     max_reg, max_next;
    logic [MV_W-1:0]     min_reg, min_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                win_valid_reg, win_valid_next;
    tmbg_win_t           win_reg, win_next;

    logic [MV_W-1:0]     max_upd;
    logic [MV_W-1:0]     min_upd;
    logic [SUM_W-1:0]    sum_upd;

    // Scale to millivolts: the product never reaches 2^24
    assign scaled = SCALED_W'(adc_sample) * SCALED_W'(MV_FULL_SCALE);

    // Handshake: the mv stage drains unless a closing item meets a full window slot
    assign last         = (count_reg == COUNT_W'(WINDOW_LEN - 1));
    assign take_mv      = mv_valid_reg && (!last || !win_valid_reg || win_ready);
    assign sample_stall = mv_valid_reg && !take_mv;
    assign accept       = sample_valid && !sample_stall;

    // Running statistics including the item in the mv stage; ties keep the old value
    assign max_upd = (mv_reg > max_reg) ? mv_reg : max_reg;
    assign min_upd = (mv_reg < min_reg) ? mv_reg : min_reg;
    assign sum_upd = sum_reg + SUM_W'(mv_reg);

    always_comb
    begin
        mv_valid_next  = accept || (mv_valid_reg && !take_mv);
        count_next     = count_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        sum_next       = sum_reg;
        win_valid_next = win_valid_reg && !win_ready;
        win_next       = win_reg;
        if (take_mv)
        begin
            if (last)
            begin
                // Window closes: hand off totals, restart the accumulators
                win_valid_next = 1'b1;
                win_next.sum   = sum_upd;
                win_next.max   = max_upd;
                win_next.min   = min_upd;
                count_next     = '0;
                max_next       = '0;
                min_next       = MIN_INIT;
                sum_next       = '0;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
                max_next   = max_upd;
                min_next   = min_upd;
                sum_next   = sum_upd;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_valid_reg  <= 1'b0;
            count_reg     <= '0;
            max_reg       <= '0;
            min_reg       <= MIN_INIT;
            sum_reg       <= '0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            mv_valid_reg  <= mv_valid_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            sum_reg       <= sum_next;
            win_valid_reg <= win_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mv_reg <= scaled[ADC_W +: MV_W];
        end
        win_reg <= win_next;
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;

    `TMBG_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1,
        count_reg <= COUNT_W'(WINDOW_LEN - 1), "sample count beyond window")
    `TMBG_ASSERT_NXT(a_restart, clk, rst_n, take_mv && last,
        count_reg == '0 && sum_reg == '0 && min_reg == MIN_INIT, "window did not restart")
    `TMBG_ASSERT_IMP(a_win_order, clk, rst_n, win_valid_reg,
        win_reg.max >= win_reg.min, "window max below min")

endmodule

// ===== rtl/tmbg_level.sv =====
`include "trimmed_mean_battery_gauge_top_defines.svh"

module tmbg_level
    import tmbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               win_valid,
    output logic               win_ready,
    input  tmbg_win_t          win,
    input  logic [MV_W-1:0]    empty_mv,
    input  logic [MV_W-1:0]    full_mv,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [LEVEL_W-1:0] level_percent,
    output logic [MV_W-1:0]    average_mv,
    output logic               low_battery
);

    typedef struct packed {
        logic [MV_W-1:0] avg;
        logic [MV_W-1:0] diff;
        logic            below;
        logic            above;
    } trim_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [MV_W-1:0]   avg;
        logic              below;
        logic              above;
    } quot_t;

    logic               ready_out, ready4, ready3;
    logic [SUM_W-1:0]   trimmed;
    logic [MV_W-1:0]    avg;
    logic [MV_W-1:0]    q;
    logic [LEVEL_W-1:0] level;

    logic               s3_valid_reg, s3_valid_next;
    trim_t              s3_reg, s3_next;
    logic               s4_valid_reg, s4_valid_next;
    quot_t              s4_reg, s4_next;
    logic               result_valid_reg, result_valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [MV_W-1:0]    avg_out_reg, avg_out_next;
    logic               low_reg, low_next;

    // Stage ready chain; each stage moves when the next has room
    assign ready_out = !result_valid_reg || !result_stall;
    assign ready4    = !s4_valid_reg || ready_out;
    assign ready3    = !s3_valid_reg || ready4;
    assign win_ready = ready3;

    // Trim: drop one max and one min, average the rest
    assign trimmed = win.sum - SUM_W'(win.max) - SUM_W'(win.min);
    assign avg     = MV_W'(trimmed >> LOG2_KEPT);

    // Level from the quotient, saturated at full
    assign q = s4_reg.prod[RECIP_SHIFT +: MV_W];

    always_comb
    begin
        if (s4_reg.below)
        begin
            level = '0;
        end
        else if (s4_reg.above || q > MV_W'(STEPS_FULL))
        begin
            level = LEVEL_W'(LEVEL_FULL);
        end
        else
        begin
            level = LEVEL_W'(q) * LEVEL_W'(LEVEL_STEP);
        end
    end

    always_comb
    begin
        s3_valid_next     = s3_valid_reg;
        s3_next           = s3_reg;
        s4_valid_next     = s4_valid_reg;
        s4_next           = s4_reg;
        result_valid_next = result_valid_reg;
        level_next        = level_reg;
        avg_out_next      = avg_out_reg;
        low_next          = low_reg;

        // Output register
        if (ready_out)
        begin
            result_valid_next = s4_valid_reg;
            level_next        = level;
            avg_out_next      = s4_reg.avg;
            low_next          = (level == '0);
        end

        // Reciprocal multiply stage
        if (ready4)
        begin
            s4_valid_next = s3_valid_reg;
            s4_next.prod  = PROD_W'(s3_reg.diff) * PROD_W'(RECIP);
            s4_next.avg   = s3_reg.avg;
            s4_next.below = s3_reg.below;
            s4_next.above = s3_reg.above;
        end

        // Trim and threshold stage
        if (ready3)
        begin
            s3_valid_next = win_valid;
            s3_next.avg   = avg;
            s3_next.diff  = avg - empty_mv;
            s3_next.below = (avg < empty_mv);
            s3_next.above = (avg > full_mv);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg     <= s3_valid_next;
            s4_valid_reg     <= s4_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s3_reg      <= s3_next;
        s4_reg      <= s4_next;
        level_reg   <= level_next;
        avg_out_reg <= avg_out_next;
        low_reg     <= low_next;
    end

    assign result_valid  = result_valid_reg;
    assign level_percent = level_reg;
    assign average_mv    = avg_out_reg;
    assign low_battery   = low_reg;

    `TMBG_ASSERT_IMP(a_level_range, clk, rst_n, result_valid_reg,
        level_reg <= LEVEL_W'(LEVEL_FULL), "level above full")
    `TMBG_ASSERT_NXT(a_s3_hold, clk, rst_n, s3_valid_reg && !ready4,
        s3_valid_reg && $stable(s3_reg), "trim stage lost its item")
    `TMBG_ASSERT_NXT(a_s4_hold, clk, rst_n, s4_valid_reg && !ready_out,
        s4_valid_reg && $stable(s4_reg), "quotient stage lost its item")

endmodule

// ===== rtl/trimmed_mean_battery_gauge_top.sv =====
// Battery level gauge from raw 12-bit converter samples.
// Sample channel: sample_valid / sample_stall with adc_sample; one item per cycle
// is taken while the pipeline has room. Each sample is scaled to millivolts and
// folded into a running min, max and sum over a window of 2^LOG2_KEPT + 2 samples.
// Result channel: result_valid / result_stall with level_percent, average_mv and
// low_battery; one result per closed window, none for the other samples.
// Path: a result follows the window's last sample through the scale register,
// window close, trim/compare, reciprocal multiply, then the output register.
// Throughput: one sample per cycle while sample_stall is low, set by the accumulate
// loop on min, max and sum; a result costs one pass of the 3-stage level pipeline.
// Stall: a waiting result holds its output register; the stages behind it keep
// filling, and sample_stall rises only when a closing sample finds no room.
// Config: cfg_valid / cfg_ready write port, always ready; index 0 is empty_mv,
// index 1 is full_mv, other indexes are ignored.
// Reset: thresholds return to 1700 mV and 2050 mV, the window restarts empty and
// all stages are cleared; no sweep is needed.
module trimmed_mean_battery_gauge_top
    import tmbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  logic [ADC_W-1:0]      adc_sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [LEVEL_W-1:0]    level_percent,
    output logic [MV_W-1:0]       average_mv,
    output logic                  low_battery,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic            win_valid;
    logic            win_ready;
    tmbg_win_t       win;
    logic [MV_W-1:0] empty_mv_reg, empty_mv_next;
    logic [MV_W-1:0] full_mv_reg, full_mv_next;

    // Threshold registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        empty_mv_next = empty_mv_reg;
        full_mv_next  = full_mv_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EMPTY_MV: empty_mv_next = MV_W'(cfg_data);
                CFG_FULL_MV:  full_mv_next  = MV_W'(cfg_data);
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_mv_reg <= EMPTY_MV_RESET;
            full_mv_reg  <= FULL_MV_RESET;
        end
        else
        begin
            empty_mv_reg <= empty_mv_next;
            full_mv_reg  <= full_mv_next;
        end
    end

    // Scale and window accumulation
    tmbg_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .adc_sample   (adc_sample),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win          (win)
    );

    // Trimmed mean and level mapping
    tmbg_level u_level (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_valid     (win_valid),
        .win_ready     (win_ready),
        .win           (win),
        .empty_mv      (empty_mv_reg),
        .full_mv       (full_mv_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .level_percent (level_percent),
        .average_mv    (average_mv),
        .low_battery   (low_battery)
    );

endmodule
